>>> sv/two_partial_decaying_tone_synth_core_defines.svh
// Assertion macros used by the sample engine of the tone synthesiser.
`ifndef TWO_PARTIAL_DECAYING_TONE_SYNTH_CORE_DEFINES_SVH
`define TWO_PARTIAL_DECAYING_TONE_SYNTH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TPDTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
`define TPDTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define TPDTS_ASSERT(lbl, prop)
`define TPDTS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/tpdts_pkg.sv
// Types, constants and the sine table function of the tone synthesiser.
`timescale 1ns / 1ps

package tpdts_pkg;

  localparam int PHASE_BITS_DEF       = 32;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_MAIN_STEP = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OVER_STEP = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ENV_STEP  = 3'd4;

  localparam logic [30:0] MAIN_STEP_RST = 31'd42852370;
  localparam logic [30:0] OVER_STEP_RST = 31'd73706076;
  localparam logic [15:0] GAIN_RST      = 16'd11796;
  localparam logic [15:0] LENGTH_RST    = 16'd7497;
  localparam logic [23:0] ENV_STEP_RST  = 24'd1902;

  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [24:0] ENV_ONE     = 25'h1000000;
  localparam logic [15:0] OVER_WEIGHT = 16'd11469;
  localparam logic [15:0] SINE_FULL   = 16'd32767;
  localparam logic [30:0] SAT_LIMIT   = 31'h40000000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef enum logic {
    CMD_TICK,
    CMD_START
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_SINE,
    ST_MIX,
    ST_GAIN,
    ST_ENV,
    ST_SCALE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [30:0] main_step;
    logic [30:0] over_step;
    logic [15:0] gain;
    logic [15:0] length;
    logic [23:0] env_step;
  } cfg_t;

  // Evaluates the sine series for an angle in Q2.30 and rounds to Q1.15.
  function automatic logic [15:0] sine_entry(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    r = ($unsigned(sum) + 64'd16384) >> 15;
    if (r > 64'(SINE_FULL)) begin
      r = 64'(SINE_FULL);
    end
    return r[15:0];
  endfunction

endpackage

>>> sv/two_partial_decaying_tone_synth_core.sv
// Top level of the two-partial decaying tone synthesiser with its configuration registers.
//
// The input channel (in_valid_i, in_ready_o, start_req_i) carries one transaction per
// audio sample tick; start_req_i set restarts the tone at sample zero on that tick.
// The output channel (out_valid_o, out_ready_i) returns exactly one transaction per tick:
// a saturated signed sample with playing and last flags, or zero when no tone sounds.
// The configuration channel writes one register per transaction: index 0 main phase
// step, 1 overtone phase step, 2 volume gain, 3 tone length, 4 envelope step; other
// indices are ignored. It is always ready and should be used only while the block idles.
// A tick enters the queue at acceptance and is taken by the engine when the engine is idle;
// the engine works through eight steps per tick (pop, phase-to-address, sine lookup, mix,
// gain, envelope, scale, output) and takes no new tick until the output step has loaded
// its result into the output register, so the engine handles one tick at a time.
// A two-entry command queue lets ticks be accepted while a result waits in the output
// register; when the receiver stalls, the engine holds its finished result and the queue
// fills, after which in_ready_o falls. Reset empties the queue and output, loads the
// register defaults and leaves the tone idle with zero phases and a full envelope.
`timescale 1ns / 1ps

module two_partial_decaying_tone_synth_core #(
  parameter int PHASE_BITS       = tpdts_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = tpdts_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               start_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [15:0]                 out_sample_o,
  output logic                               out_playing_o,
  output logic                               out_last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tpdts_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [tpdts_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  tpdts_pkg::cfg_t  cfg_q;
  logic             cmd_valid, cmd_ready;
  tpdts_pkg::cmd_e  cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.main_step <= tpdts_pkg::MAIN_STEP_RST;
      cfg_q.over_step <= tpdts_pkg::OVER_STEP_RST;
      cfg_q.gain      <= tpdts_pkg::GAIN_RST;
      cfg_q.length    <= tpdts_pkg::LENGTH_RST;
      cfg_q.env_step  <= tpdts_pkg::ENV_STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tpdts_pkg::REG_MAIN_STEP: cfg_q.main_step <= cfg_data_i[30:0];
        tpdts_pkg::REG_OVER_STEP: cfg_q.over_step <= cfg_data_i[30:0];
        tpdts_pkg::REG_GAIN:      cfg_q.gain      <= cfg_data_i[15:0];
        tpdts_pkg::REG_LENGTH:    cfg_q.length    <= cfg_data_i[15:0];
        tpdts_pkg::REG_ENV_STEP:  cfg_q.env_step  <= cfg_data_i[23:0];
        default: begin
        end
      endcase
    end
  end

  tpdts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_req_i (start_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  tpdts_back #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_sample_o  (out_sample_o),
    .out_playing_o (out_playing_o),
    .out_last_o    (out_last_o)
  );

endmodule

>>> sv/tpdts_front.sv
// Input side of the tone synthesiser: accepts ticks, classifies them and queues commands.
`timescale 1ns / 1ps

module tpdts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               start_req_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output tpdts_pkg::cmd_e    cmd_o
);

  tpdts_pkg::cmd_e                       q_mem_q [tpdts_pkg::QUEUE_DEPTH];
  logic [tpdts_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [tpdts_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [tpdts_pkg::QUEUE_CNT_W-1:0]     count_q, count_d;
  logic                                  push, pop;
  tpdts_pkg::cmd_e                       cmd_class;

  assign in_ready_o  = (count_q != tpdts_pkg::QUEUE_CNT_W'(tpdts_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_class   = start_req_i ? tpdts_pkg::CMD_START : tpdts_pkg::CMD_TICK;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_class;
    end
  end

endmodule

>>> sv/tpdts_back.sv
// Sample engine of the tone synthesiser: tone state, sine lookup, mixing and output register.
`timescale 1ns / 1ps
`include "two_partial_decaying_tone_synth_core_defines.svh"

module tpdts_back #(
  parameter int PHASE_BITS       = tpdts_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = tpdts_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpdts_pkg::cfg_t     cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  tpdts_pkg::cmd_e     cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  out_sample_o,
  output logic                out_playing_o,
  output logic                out_last_o
);

  localparam int FOURD = 4 * SINE_TABLE_DEPTH;
  localparam int MULW  = $clog2(FOURD + 1);
  localparam int POSW  = $clog2(FOURD);
  localparam int IW    = $clog2(SINE_TABLE_DEPTH);
  localparam int PRODW = PHASE_BITS + MULW;

  logic [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] ARG = (64'(k) * tpdts_pkg::PI_Q30) / (2 * SINE_TABLE_DEPTH);
    assign sine_rom[k] = tpdts_pkg::sine_entry(ARG);
  end

  function automatic logic signed [15:0] sine_at(input logic [POSW-1:0] pos);
    logic [1:0]      quad;
    logic [POSW-1:0] rem;
    logic [IW-1:0]   idx;
    logic [15:0]     v;
    priority if (pos >= POSW'(3 * SINE_TABLE_DEPTH)) begin
      quad = 2'd3;
      rem  = pos - POSW'(3 * SINE_TABLE_DEPTH);
    end else if (pos >= POSW'(2 * SINE_TABLE_DEPTH)) begin
      quad = 2'd2;
      rem  = pos - POSW'(2 * SINE_TABLE_DEPTH);
    end else if (pos >= POSW'(SINE_TABLE_DEPTH)) begin
      quad = 2'd1;
      rem  = pos - POSW'(SINE_TABLE_DEPTH);
    end else begin
      quad = 2'd0;
      rem  = pos;
    end
    idx = rem[IW-1:0];
    if (quad[0]) begin
      v = (idx == '0) ? tpdts_pkg::SINE_FULL : sine_rom[IW'(SINE_TABLE_DEPTH) - idx];
    end else begin
      v = sine_rom[idx];
    end
    return quad[1] ? -$signed(v) : $signed(v);
  endfunction

  tpdts_pkg::state_e state_q, state_d;

  logic [PHASE_BITS-1:0] main_phase_q, over_phase_q;
  logic [24:0]           env_q;
  logic [15:0]           idx_q;
  logic                  active_q;

  logic [POSW-1:0]       pos_main_q, pos_over_q;
  logic signed [15:0]    s_main_q, s_over_q;
  logic                  last_q;
  logic                  neg_q;
  logic [30:0]           mag_q;
  logic [31:0]           m1_q;
  logic [30:0]           sat_q;
  logic [15:0]           mag16_q;

  logic                  out_valid_q;
  logic signed [15:0]    out_sample_q;
  logic                  out_playing_q, out_last_q;

  logic                  pop, load;
  logic [PRODW-1:0]      prod_main, prod_over;
  logic [15:0]           len, len_m1;
  logic signed [31:0]    over_w;
  logic signed [32:0]    mix;
  logic [32:0]           mix_abs;
  logic [46:0]           prod_gain;
  logic [56:0]           prod_env;
  logic [32:0]           m2;
  logic [45:0]           prod_scale;

  assign cmd_ready_o = (state_q == tpdts_pkg::ST_IDLE);
  assign pop         = cmd_ready_o && cmd_valid_i;
  assign load        = (state_q == tpdts_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

  assign prod_main  = PRODW'(main_phase_q) * PRODW'(FOURD);
  assign prod_over  = PRODW'(over_phase_q) * PRODW'(FOURD);
  assign len        = (cfg_i.length == '0) ? 16'd1 : cfg_i.length;
  assign len_m1     = len - 16'd1;
  assign over_w     = s_over_q * $signed(tpdts_pkg::OVER_WEIGHT);
  assign mix        = (33'(s_main_q) <<< 15) + 33'(over_w);
  assign mix_abs    = mix[32] ? 33'(-mix) : 33'(mix);
  assign prod_gain  = 47'(mag_q) * 47'(cfg_i.gain);
  assign prod_env   = 57'(m1_q) * 57'(env_q);
  assign m2         = prod_env[56:24];
  assign prod_scale = 46'(sat_q) * 46'(tpdts_pkg::SINE_FULL);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpdts_pkg::ST_IDLE:  if (cmd_valid_i) state_d = tpdts_pkg::ST_POS;
      tpdts_pkg::ST_POS:   state_d = tpdts_pkg::ST_SINE;
      tpdts_pkg::ST_SINE:  state_d = tpdts_pkg::ST_MIX;
      tpdts_pkg::ST_MIX:   state_d = tpdts_pkg::ST_GAIN;
      tpdts_pkg::ST_GAIN:  state_d = tpdts_pkg::ST_ENV;
      tpdts_pkg::ST_ENV:   state_d = tpdts_pkg::ST_SCALE;
      tpdts_pkg::ST_SCALE: state_d = tpdts_pkg::ST_OUT;
      tpdts_pkg::ST_OUT:   if (load) state_d = tpdts_pkg::ST_IDLE;
      default:             state_d = tpdts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpdts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_phase_q <= '0;
      over_phase_q <= '0;
      env_q        <= tpdts_pkg::ENV_ONE;
      idx_q        <= '0;
      active_q     <= 1'b0;
    end else if (pop && (cmd_i == tpdts_pkg::CMD_START)) begin
      main_phase_q <= '0;
      over_phase_q <= '0;
      env_q        <= tpdts_pkg::ENV_ONE;
      idx_q        <= '0;
      active_q     <= 1'b1;
    end else if (load && active_q) begin
      main_phase_q <= main_phase_q + PHASE_BITS'(cfg_i.main_step);
      over_phase_q <= over_phase_q + PHASE_BITS'(cfg_i.over_step);
      env_q        <= (env_q > 25'(cfg_i.env_step)) ? env_q - 25'(cfg_i.env_step) : '0;
      idx_q        <= idx_q + 16'd1;
      if (last_q) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tpdts_pkg::ST_POS: begin
        pos_main_q <= prod_main[PHASE_BITS+POSW-1:PHASE_BITS];
        pos_over_q <= prod_over[PHASE_BITS+POSW-1:PHASE_BITS];
        last_q     <= (idx_q >= len_m1);
      end
      tpdts_pkg::ST_SINE: begin
        s_main_q <= sine_at(pos_main_q);
        s_over_q <= sine_at(pos_over_q);
      end
      tpdts_pkg::ST_MIX: begin
        neg_q <= mix[32];
        mag_q <= mix_abs[30:0];
      end
      tpdts_pkg::ST_GAIN: begin
        m1_q <= prod_gain[46:15];
      end
      tpdts_pkg::ST_ENV: begin
        sat_q <= (m2 > 33'(tpdts_pkg::SAT_LIMIT)) ? tpdts_pkg::SAT_LIMIT : m2[30:0];
      end
      tpdts_pkg::ST_SCALE: begin
        mag16_q <= prod_scale[45:30];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_playing_q <= active_q;
      out_last_q    <= active_q && last_q;
      if (active_q) begin
        out_sample_q <= neg_q ? -$signed(mag16_q) : $signed(mag16_q);
      end else begin
        out_sample_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign out_playing_o = out_playing_q;
  assign out_last_o    = out_last_q;

  `TPDTS_ASSERT(a_load_from_out, $rose(out_valid_q) |-> $past(state_q == tpdts_pkg::ST_OUT))
  `TPDTS_ASSERT(a_idle_silent, (out_valid_q && !out_playing_q) |-> (out_sample_q == '0 && !out_last_q))
  `TPDTS_ASSERT(a_stop_after_last, $fell(active_q) |-> $past(last_q && state_q == tpdts_pkg::ST_OUT))
  `TPDTS_ASSERT_NEXT(a_pop_starts, pop, state_q == tpdts_pkg::ST_POS)

endmodule
